### rtl/fdss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdss_pkg
// Shared types, constants and glyph tables of the four-digit display formatter.
// ----------------------------------------------------------------------------
package fdss_pkg;

    localparam int NUMBER_W = 14;
    localparam int FAULT_W  = 8;
    localparam int ADDR_W   = 7;
    localparam int SEG_W    = 8;
    localparam int POS_W    = 2;
    localparam int DIGIT_W  = 4;

    localparam logic [NUMBER_W-1:0] VALUE_MAX  = 14'd9999;
    localparam logic [POS_W-1:0]    POS_FIRST  = 2'd0;
    localparam logic [POS_W-1:0]    POS_SECOND = 2'd1;
    localparam logic [POS_W-1:0]    POS_THIRD  = 2'd2;
    localparam logic [POS_W-1:0]    POS_LAST   = 2'd3;
    localparam logic [ADDR_W-1:0]   ADDR_BASE  = 7'h68;
    localparam logic [ADDR_W-1:0]   ADDR_LAST  = 7'h6E;
    localparam logic [SEG_W-1:0]    GLYPH_E    = 8'h79;
    localparam logic [SEG_W-1:0]    GLYPH_R    = 8'h50;
    localparam logic [SEG_W-1:0]    GLYPH_BLANK = 8'h00;

    // one queued job: fault jobs carry the fault code in value
    typedef struct packed {
        logic                is_fault;
        logic [NUMBER_W-1:0] value;
    } fdss_job_t;

    typedef enum logic [1:0] {
        SCALE_THOU = 2'd0,
        SCALE_HUND = 2'd1,
        SCALE_TENS = 2'd2,
        SCALE_ONES = 2'd3
    } fdss_scale_t;

    function automatic logic [SEG_W-1:0] fdss_glyph(input logic [DIGIT_W-1:0] digit);
        logic [SEG_W-1:0] seg;
        unique case (digit)
            4'd0:    seg = 8'h3F;
            4'd1:    seg = 8'h06;
            4'd2:    seg = 8'h5B;
            4'd3:    seg = 8'h4F;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'h6D;
            4'd6:    seg = 8'h7D;
            4'd7:    seg = 8'h07;
            4'd8:    seg = 8'h7F;
            4'd9:    seg = 8'h6F;
            default: seg = GLYPH_BLANK;
        endcase
        return seg;
    endfunction

    // k times the place weight, k in 0..9
    function automatic logic [NUMBER_W-1:0] fdss_multiple(input fdss_scale_t scale,
                                                          input logic [DIGIT_W-1:0] k);
        logic [NUMBER_W-1:0] kx;
        logic [NUMBER_W-1:0] prod;
        kx = NUMBER_W'(k);
        unique case (scale)
            SCALE_THOU: prod = NUMBER_W'(kx * 14'd1000);
            SCALE_HUND: prod = NUMBER_W'(kx * 14'd100);
            SCALE_TENS: prod = NUMBER_W'(kx * 14'd10);
            SCALE_ONES: prod = kx;
            default:    prod = kx;
        endcase
        return prod;
    endfunction

endpackage
`default_nettype wire

### rtl/fdss_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdss_front
// Input side: takes items, sorts value and fault requests, clamps values.
// ----------------------------------------------------------------------------
module fdss_front
    import fdss_pkg::*;
(
    input  wire logic                in_valid,
    output      logic                in_ready,
    input  wire logic                action,
    input  wire logic [NUMBER_W-1:0] number,
    input  wire logic [FAULT_W-1:0]  fault_code,
    output      logic                push_valid,
    input  wire logic                push_ready,
    output      fdss_job_t           push_job
);

    logic [NUMBER_W-1:0] clamped;

    assign clamped    = (number > VALUE_MAX) ? VALUE_MAX : number;
    assign in_ready   = push_ready;
    assign push_valid = in_valid;

    always_comb
    begin
        push_job.is_fault = action;
        // fault items only need the code in the job payload
        push_job.value    = action ? NUMBER_W'(fault_code) : clamped;
    end

endmodule
`default_nettype wire

### rtl/fdss_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdss_queue
// Two-entry job queue between the front and the digit back end.
// ----------------------------------------------------------------------------
module fdss_queue
    import fdss_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push_valid,
    output      logic      push_ready,
    input  wire fdss_job_t push_job,
    output      logic      pop_valid,
    input  wire logic      pop_ready,
    output      fdss_job_t pop_job
);

    fdss_job_t   entry_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        push;
    logic        pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_job    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule
`default_nettype wire

### rtl/fdss_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdss_back
// Digit back end: peels one decimal digit per cycle unless stalled and emits digit writes.
// ----------------------------------------------------------------------------
module fdss_back
    import fdss_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                job_valid,
    output      logic                job_ready,
    input  wire fdss_job_t           job,
    output      logic                out_valid,
    input  wire logic                out_ready,
    output      logic [ADDR_W-1:0]   digit_address,
    output      logic [SEG_W-1:0]    segments,
    output      logic                last
);

    logic [POS_W-1:0]    pos_reg;
    logic [POS_W-1:0]    pos_next;
    logic                fault_reg;
    logic [NUMBER_W-1:0] rem_reg;
    logic [NUMBER_W-1:0] rem_next;
    logic                blank_reg;
    logic                blank_next;
    logic                out_valid_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [SEG_W-1:0]    seg_reg;
    logic [SEG_W-1:0]    seg_next;
    logic                last_reg;

    logic                at_first;
    logic                step;
    logic                is_fault;
    logic [NUMBER_W-1:0] rem_cur;
    logic                blank_cur;
    fdss_scale_t         scale;
    logic [DIGIT_W-1:0]  digit;

    assign at_first  = (pos_reg == POS_FIRST);
    // position 0 reads straight from the queue head so items run back to back
    assign step      = (!at_first || job_valid) && (!out_valid_reg || out_ready);
    assign job_ready = at_first && (!out_valid_reg || out_ready);

    assign is_fault  = at_first ? job.is_fault : fault_reg;
    assign rem_cur   = at_first ? job.value : rem_reg;
    assign blank_cur = at_first ? 1'b1 : blank_reg;
    assign pos_next  = pos_reg + POS_W'(1);

    always_comb
    begin
        unique case (pos_reg)
            POS_FIRST:  scale = is_fault ? SCALE_HUND : SCALE_THOU;
            POS_SECOND: scale = is_fault ? SCALE_TENS : SCALE_HUND;
            POS_THIRD:  scale = SCALE_TENS;
            POS_LAST:   scale = SCALE_ONES;
            default:    scale = SCALE_ONES;
        endcase
    end

    // largest k with k * weight <= remainder
    always_comb
    begin
        digit = '0;
        for (int k = 1; k <= 9; k++)
        begin
            if (rem_cur >= fdss_multiple(scale, DIGIT_W'(k)))
            begin
                digit = DIGIT_W'(k);
            end
        end
        rem_next   = rem_cur - fdss_multiple(scale, digit);
        blank_next = blank_cur && (digit == '0);
    end

    always_comb
    begin
        if (is_fault)
        begin
            unique case (pos_reg)
                POS_FIRST:  seg_next = GLYPH_E;
                POS_SECOND: seg_next = GLYPH_R;
                POS_THIRD:  seg_next = GLYPH_R;
                POS_LAST:   seg_next = fdss_glyph(digit);
                default:    seg_next = GLYPH_BLANK;
            endcase
        end
        else if ((pos_reg != POS_LAST) && blank_next)
        begin
            // leading zero
            seg_next = GLYPH_BLANK;
        end
        else
        begin
            seg_next = fdss_glyph(digit);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                pos_reg       <= pos_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            fault_reg <= is_fault;
            rem_reg   <= rem_next;
            blank_reg <= blank_next;
            addr_reg  <= ADDR_BASE | ADDR_W'({pos_reg, 1'b0});
            seg_reg   <= seg_next;
            last_reg  <= (pos_reg == POS_LAST);
        end
    end

    assign out_valid     = out_valid_reg;
    assign digit_address = addr_reg;
    assign segments      = seg_reg;
    assign last          = last_reg;

endmodule
`default_nettype wire

### rtl/four_digit_seven_segment_formatter.sv
// the first digit write of an item, when the back end is idle, is registered first in the queue
//   and then in the output registers of the digit step
// throughput: four results per item, one per cycle while out_ready is high; one item at a time
//   in the back end, as its single digit step unit handles one position a cycle
// a two-entry queue lets new items in while the back end is still writing digits
// reset: asynchronous, clears the queue and the output valid; no memory clearing pass
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// four_digit_seven_segment_formatter
// Turns value or fault requests into four seven-segment digit register writes.
// ----------------------------------------------------------------------------
module four_digit_seven_segment_formatter
    import fdss_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output      logic                in_ready,
    input  wire logic                action,
    input  wire logic [NUMBER_W-1:0] number,
    input  wire logic [FAULT_W-1:0]  fault_code,
    output      logic                out_valid,
    input  wire logic                out_ready,
    output      logic [ADDR_W-1:0]   digit_address,
    output      logic [SEG_W-1:0]    segments,
    output      logic                last
);

    logic      push_valid;
    logic      push_ready;
    fdss_job_t push_job;
    logic      job_valid;
    logic      job_ready;
    fdss_job_t job;

    fdss_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .number     (number),
        .fault_code (fault_code),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    fdss_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (job_valid),
        .pop_ready  (job_ready),
        .pop_job    (job)
    );

    fdss_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_valid     (job_valid),
        .job_ready     (job_ready),
        .job           (job),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .digit_address (digit_address),
        .segments      (segments),
        .last          (last)
    );

`ifndef SYNTHESIS
    // last marks exactly the final digit register
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (digit_address == ADDR_LAST)))
        else $error("last flag does not match digit position");

    // once an item has started, its remaining digit writes follow without gaps
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last) |=> out_valid)
        else $error("gap inside an item's digit writes");

    // the decimal point segment is never driven
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !segments[SEG_W-1])
        else $error("segment bit 7 set");

    // a taken item reaches the back end or waits in the queue
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> job_valid)
        else $error("accepted item not queued");
`endif

endmodule
`default_nettype wire
